### rtl/cubic_trajectory_generator_unit_macros.svh
// Assertion helpers for the trajectory generator; clocked on clk, held off in reset.
`ifndef CUBIC_TRAJECTORY_GENERATOR_UNIT_MACROS_SVH
`define CUBIC_TRAJECTORY_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define CTG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ctg_pkg.sv
`default_nettype none

package ctg_pkg;

    typedef enum logic [1:0] {
        REG_START    = 2'd0,
        REG_END      = 2'd1,
        REG_DURATION = 2'd2
    } reg_idx_t;

    localparam int          ADDR_W       = 4;
    localparam int          TIME_W       = 32;
    localparam int          ANGLE_W      = 32;
    localparam int          RATE_Q_W     = 52;
    localparam int          POS_W        = 36;
    localparam logic [31:0] DUR_RESET    = 32'h0001_0000;
    localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
    localparam logic [36:0] SIX_Q32      = 37'h06_0000_0000;

    // payload riding alongside the velocity rate divider
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             kneg;
        logic             done;
    } rate_tag_t;

    typedef struct packed {
        logic ge;
        logic done;
    } time_tag_t;

endpackage

`default_nettype wire

### rtl/ctg_in_if.sv
`default_nettype none

interface ctg_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] elapsed_time;

    modport source (output valid, output elapsed_time, input ready);
    modport sink   (input valid, input elapsed_time, output ready);
endinterface

`default_nettype wire

### rtl/ctg_out_if.sv
`default_nettype none

interface ctg_out_if #(parameter int DATA_WIDTH = 32);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] position;
    logic [DATA_WIDTH-1:0] velocity;
    logic [DATA_WIDTH-1:0] acceleration;
    logic                  move_done;

    modport source (output valid, output position, output velocity, output acceleration,
                    output move_done, input ready);
    modport sink   (input valid, input position, input velocity, input acceleration,
                    input move_done, output ready);
endinterface

`default_nettype wire

### rtl/ctg_div.sv
`default_nettype none

// Restoring divider, one quotient bit per register stage.
module ctg_div
    import ctg_pkg::*;
#(
    parameter int Q_W   = 32,
    parameter int DEN_W = 32,
    parameter int TAG_W = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [DEN_W-1:0] in_rem,
    input  wire logic [Q_W-1:0]   in_num,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic [TAG_W-1:0] in_tag,
    output logic                  out_valid,
    output logic [Q_W-1:0]        out_quo,
    output logic [TAG_W-1:0]      out_tag
);

    logic             valid_reg [Q_W];
    logic [DEN_W-1:0] rem_reg   [Q_W];
    logic [Q_W-1:0]   nq_reg    [Q_W];
    logic [TAG_W-1:0] tag_reg   [Q_W];

    genvar i;
    for (i = 0; i < Q_W; i++)
    begin : g_stage
        logic             pv;
        logic [DEN_W-1:0] prem;
        logic [Q_W-1:0]   pnq;
        logic [TAG_W-1:0] ptag;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;
        logic [DEN_W-1:0] rem_next;
        logic [Q_W-1:0]   nq_next;

        if (i == 0)
        begin : g_first
            assign pv   = in_valid;
            assign prem = in_rem;
            assign pnq  = in_num;
            assign ptag = in_tag;
        end
        else
        begin : g_rest
            assign pv   = valid_reg[i-1];
            assign prem = rem_reg[i-1];
            assign pnq  = nq_reg[i-1];
            assign ptag = tag_reg[i-1];
        end

        assign trial    = {prem, pnq[Q_W-1]};
        assign diff     = trial - {1'b0, den};
        assign take     = trial >= {1'b0, den};
        assign rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign nq_next  = {pnq[Q_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                nq_reg[i]  <= nq_next;
                tag_reg[i] <= ptag;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_quo   = nq_reg[Q_W-1];
    assign out_tag   = tag_reg[Q_W-1];

endmodule

`default_nettype wire

### rtl/cubic_trajectory_generator_unit.sv
// Cubic point-to-point trajectory generator.
// Configure start_angle (0x0), end_angle (0x4) and move_duration (0x8) over the
// APB port while no transfer is in flight; reads return the register contents.
// Each input transfer carries an elapsed time (unsigned Q16.16 s); each yields
// one output transfer with position and velocity (signed Q16.16), acceleration
// (signed integer), all saturated to DATA_WIDTH, and move_done, in order.
// Data passes through 91 register stages: one capture stage, a 32-stage
// divider for t/T, five arithmetic stages (M1 to M5), 52-stage dividers for
// the velocity and acceleration quotients, and the output register.
// Throughput is one item per cycle while the receiver takes the outputs;
// the dividers' one-bit-per-stage pipelines set the latency.
// Reset clears all valid bits and loads the register reset values
// (duration 1.0 s). When the receiver holds ready low with a result pending,
// the whole pipeline freezes and input ready drops; nothing is lost.
`default_nettype none

`include "cubic_trajectory_generator_unit_macros.svh"

module cubic_trajectory_generator_unit
    import ctg_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    ctg_in_if.sink                 in_ch,
    ctg_out_if.source              out_ch
);

    // ---------------- configuration
    logic [31:0] start_reg;
    logic [31:0] end_reg;
    logic [31:0] dur_reg;
    reg_idx_t    reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
            dur_reg   <= DUR_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_START:    start_reg <= pwdata;
                REG_END:      end_reg   <= pwdata;
                REG_DURATION: dur_reg   <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_START:    prdata = start_reg;
            REG_END:      prdata = end_reg;
            REG_DURATION: prdata = dur_reg;
            default:      prdata = '0;
        endcase
    end

    // derived move constants
    logic [31:0] dur_eff;
    logic [32:0] dlt;
    logic [31:0] dur_eff_reg;
    logic [63:0] dur_sq_reg;
    logic [32:0] dmag_reg;
    logic        dneg_reg;

    assign dur_eff = (dur_reg == '0) ? 32'd1 : dur_reg;
    assign dlt     = {end_reg[31], end_reg} - {start_reg[31], start_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_eff_reg <= DUR_RESET;
            dur_sq_reg  <= 64'h1_0000_0000;
            dmag_reg    <= '0;
            dneg_reg    <= 1'b0;
        end
        else
        begin
            dur_eff_reg <= dur_eff;
            dur_sq_reg  <= 64'(dur_eff_reg) * 64'(dur_eff_reg);
            dmag_reg    <= dlt[32] ? (33'd0 - dlt) : dlt;
            dneg_reg    <= dlt[32];
        end
    end

    // ---------------- pipeline control
    logic en;
    logic out_valid_reg;

    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // ---------------- capture
    logic        in_valid_reg;
    logic [31:0] t_reg;
    logic        ge_reg;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg    <= in_ch.elapsed_time;
            ge_reg   <= in_ch.elapsed_time >= dur_eff;
            done_reg <= in_ch.elapsed_time > dur_eff;
        end
    end

    // ---------------- s = t / T, Q0.32
    logic             sd_valid;
    logic [31:0]      sd_quo;
    logic [1:0]       sd_tag_bits;
    time_tag_t        sd_tag_in;
    time_tag_t        sd_tag;

    assign sd_tag_in = '{ge: ge_reg, done: done_reg};
    assign sd_tag    = time_tag_t'(sd_tag_bits);

    ctg_div #(
        .Q_W   (32),
        .DEN_W (32),
        .TAG_W ($bits(time_tag_t))
    ) u_time_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_rem    (ge_reg ? 32'd0 : t_reg),
        .in_num    (32'd0),
        .den       (dur_eff_reg),
        .in_tag    (sd_tag_in),
        .out_valid (sd_valid),
        .out_quo   (sd_quo),
        .out_tag   (sd_tag_bits)
    );

    // ---------------- M1: s^2
    logic        m1_valid_reg;
    logic [31:0] m1_s_reg;
    logic [63:0] m1_ss_reg;
    logic        m1_ge_reg;
    logic        m1_done_reg;

    // ---------------- M2: s2, g, s2*s
    logic        m2_valid_reg;
    logic [31:0] m2_s_reg;
    logic [31:0] m2_s2_reg;
    logic [31:0] m2_g_reg;
    logic [63:0] m2_s3p_reg;
    logic        m2_ge_reg;
    logic        m2_done_reg;
    logic [31:0] m1_s2;

    assign m1_s2 = m1_ss_reg[63:32];

    // ---------------- M3: h, 6g, k
    logic        m3_valid_reg;
    logic [32:0] m3_h_reg;
    logic [32:0] m3_g6_reg;
    logic [34:0] m3_kmag_reg;
    logic        m3_kneg_reg;
    logic        m3_done_reg;
    logic [34:0] h_full;
    logic [32:0] h_next;
    logic [32:0] g_eff;
    logic [32:0] s_eff;
    logic [36:0] twelve_s;
    logic [36:0] k_pos;
    logic [36:0] k_neg;

    always_comb
    begin
        h_full   = 35'(m2_s2_reg) + 35'({m2_s2_reg, 1'b0}) - 35'({m2_s3p_reg[63:32], 1'b0});
        h_next   = m2_ge_reg ? ONE_Q32 : h_full[32:0];
        g_eff    = m2_ge_reg ? 33'd0 : {1'b0, m2_g_reg};
        s_eff    = m2_ge_reg ? ONE_Q32 : {1'b0, m2_s_reg};
        twelve_s = 37'({s_eff, 3'b000}) + 37'({s_eff, 2'b00});
        k_pos    = SIX_Q32 - twelve_s;
        k_neg    = twelve_s - SIX_Q32;
    end

    // ---------------- M4: products with |D|
    logic        m4_valid_reg;
    logic [65:0] m4_ph_reg;
    logic [65:0] m4_pv_reg;
    logic [67:0] m4_pa_reg;
    logic        m4_kneg_reg;
    logic        m4_done_reg;

    // ---------------- M5: position, quotient numerators
    logic                m5_valid_reg;
    logic [POS_W-1:0]    m5_pos_reg;
    logic [49:0]         m5_nv_reg;
    logic [RATE_Q_W-1:0] m5_na_reg;
    logic                m5_kneg_reg;
    logic                m5_done_reg;
    logic [POS_W-1:0]    start_ext;
    logic [POS_W-1:0]    m_ext;

    assign start_ext = {{(POS_W-32){start_reg[31]}}, start_reg};
    assign m_ext     = POS_W'(m4_ph_reg[65:32]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
            m4_valid_reg <= 1'b0;
            m5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= sd_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
            m4_valid_reg <= m3_valid_reg;
            m5_valid_reg <= m4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_s_reg    <= sd_quo;
            m1_ss_reg   <= 64'(sd_quo) * 64'(sd_quo);
            m1_ge_reg   <= sd_tag.ge;
            m1_done_reg <= sd_tag.done;

            // g = floor(s(1-s)) = s - ceil(s^2)
            m2_s_reg    <= m1_s_reg;
            m2_s2_reg   <= m1_s2;
            m2_g_reg    <= m1_s_reg - m1_s2 - 32'(|m1_ss_reg[31:0]);
            m2_s3p_reg  <= 64'(m1_s2) * 64'(m1_s_reg);
            m2_ge_reg   <= m1_ge_reg;
            m2_done_reg <= m1_done_reg;

            m3_h_reg    <= h_next;
            m3_g6_reg   <= 33'({g_eff, 2'b00}) + 33'({g_eff, 1'b0});
            m3_kneg_reg <= twelve_s > SIX_Q32;
            m3_kmag_reg <= (twelve_s > SIX_Q32) ? k_neg[34:0] : k_pos[34:0];
            m3_done_reg <= m2_done_reg;

            m4_ph_reg   <= 66'(dmag_reg) * 66'(m3_h_reg);
            m4_pv_reg   <= 66'(dmag_reg) * 66'(m3_g6_reg);
            m4_pa_reg   <= 68'(dmag_reg) * 68'(m3_kmag_reg);
            m4_kneg_reg <= m3_kneg_reg;
            m4_done_reg <= m3_done_reg;

            m5_pos_reg  <= dneg_reg ? (start_ext - m_ext) : (start_ext + m_ext);
            m5_nv_reg   <= m4_pv_reg[65:16];
            m5_na_reg   <= m4_pa_reg[67:16];
            m5_kneg_reg <= m4_kneg_reg;
            m5_done_reg <= m4_done_reg;
        end
    end

    // ---------------- rate dividers: /T and /T^2
    rate_tag_t             rt_in;
    rate_tag_t             rt_out;
    logic [$bits(rate_tag_t)-1:0] rt_bits;
    logic                  vel_valid;
    logic                  acc_valid;
    logic [RATE_Q_W-1:0]   vel_quo;
    logic [RATE_Q_W-1:0]   acc_quo;
    logic                  acc_done;

    assign rt_in  = '{pos: m5_pos_reg, kneg: m5_kneg_reg, done: m5_done_reg};
    assign rt_out = rate_tag_t'(rt_bits);

    ctg_div #(
        .Q_W   (RATE_Q_W),
        .DEN_W (32),
        .TAG_W ($bits(rate_tag_t))
    ) u_vel_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m5_valid_reg),
        .in_rem    (32'd0),
        .in_num    (RATE_Q_W'(m5_nv_reg)),
        .den       (dur_eff_reg),
        .in_tag    (rt_in),
        .out_valid (vel_valid),
        .out_quo   (vel_quo),
        .out_tag   (rt_bits)
    );

    ctg_div #(
        .Q_W   (RATE_Q_W),
        .DEN_W (64),
        .TAG_W (1)
    ) u_acc_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m5_valid_reg),
        .in_rem    (64'd0),
        .in_num    (m5_na_reg),
        .den       (dur_sq_reg),
        .in_tag    (m5_done_reg),
        .out_valid (acc_valid),
        .out_quo   (acc_quo),
        .out_tag   (acc_done)
    );

    // ---------------- output register
    function automatic logic [DATA_WIDTH-1:0] sat(input logic neg, input logic [63:0] mag);
        logic [64:0] lim;
        logic [64:0] m;
        logic [64:0] r;
        lim = (65'd1 << (DATA_WIDTH - 1)) - {64'd0, !neg};
        m   = ({1'b0, mag} > lim) ? lim : {1'b0, mag};
        r   = neg ? (65'd0 - m) : m;
        return r[DATA_WIDTH-1:0];
    endfunction

    logic [RATE_Q_W-1:0]   aq;
    logic                  pos_neg;
    logic [POS_W-1:0]      pos_mag;
    logic [DATA_WIDTH-1:0] position_reg;
    logic [DATA_WIDTH-1:0] velocity_reg;
    logic [DATA_WIDTH-1:0] acceleration_reg;
    logic                  move_done_reg;

    assign aq      = acc_done ? '0 : acc_quo;
    assign pos_neg = rt_out.pos[POS_W-1];
    assign pos_mag = pos_neg ? (POS_W'(0) - rt_out.pos) : rt_out.pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            position_reg     <= sat(pos_neg, 64'(pos_mag));
            velocity_reg     <= sat(dneg_reg && (vel_quo != '0), 64'(vel_quo));
            acceleration_reg <= sat((dneg_reg != rt_out.kneg) && (aq != '0), 64'(aq));
            move_done_reg    <= rt_out.done;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.position     = position_reg;
    assign out_ch.velocity     = velocity_reg;
    assign out_ch.acceleration = acceleration_reg;
    assign out_ch.move_done    = move_done_reg;

    // ---------------- checks
    `CTG_ASSERT_IMP(a_div_lockstep, 1'b1, vel_valid == acc_valid, "rate dividers out of step")
    `CTG_ASSERT_IMP(a_done_at_rest, out_valid_reg && move_done_reg, velocity_reg == '0 && acceleration_reg == '0, "finished move not at rest")
    `CTG_ASSERT_NXT(a_in_capture, in_ch.valid && in_ch.ready, in_valid_reg, "accepted transfer not captured")

endmodule

`default_nettype wire
